@@ rtl/nearest_vector_l1_search_macros.svh @@
// ----------------------------------------------------------------------------
// nearest_vector_l1_search_macros
// Assertion macros for the nearest vector search block. Each expects clk and
// arst_n in scope.
// ----------------------------------------------------------------------------
`ifndef NEAREST_VECTOR_L1_SEARCH_MACROS_SVH
`define NEAREST_VECTOR_L1_SEARCH_MACROS_SVH

`ifndef ASSERT_OFF

// Property that holds at every clock edge outside reset.
`define NVLS_ASSERT(lbl, pexpr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pexpr)) else $error(msg);

// Condition in one cycle forces a consequence in the next.
`define NVLS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`else

`define NVLS_ASSERT(lbl, pexpr, msg)
`define NVLS_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/nvls_pkg.sv @@
// ----------------------------------------------------------------------------
// nvls_pkg
// Sizes, codes, controller/datapath bundles and helpers for the L1 search.
// ----------------------------------------------------------------------------
package nvls_pkg;

	localparam int MAX_ROWS = 16;
	localparam int MAX_LEN  = 64;

	// payload field widths
	localparam int VAL_W  = 16;
	localparam int ROW_W  = 4;
	localparam int COL_W  = 6;
	localparam int DIST_W = 22;

	// storage addressing
	localparam int ROW_AW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
	localparam int COL_AW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
	localparam int REF_AW    = ROW_AW + COL_AW;
	localparam int REF_DEPTH = MAX_ROWS * (2 ** COL_AW);
	localparam int QRY_DEPTH = 2 ** COL_AW;

	// effective counts, able to hold the maximum itself
	localparam int RCNT_W = $clog2(MAX_ROWS + 1);
	localparam int LCNT_W = $clog2(MAX_LEN + 1);

	// full-precision distance sum
	localparam int SUM_W = VAL_W + ((MAX_LEN > 1) ? $clog2(MAX_LEN) : 0);

	localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

	// configuration registers
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 7;
	localparam int RCFG_W     = 5;
	localparam int LCFG_W     = 7;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_VEC_LEN   = 2'd1;

	// item kinds
	localparam logic KIND_REF   = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef struct packed {
		logic              init_best;
		logic              init_found;
		logic              issue;
		logic              first;
		logic              row_last;
		logic [ROW_AW-1:0] row;
		logic [COL_AW-1:0] col;
		logic              load_out;
	} nvls_cmd_t;

	typedef struct packed {
		logic pipe_busy;
		logic out_free;
	} nvls_sts_t;

	function automatic logic [DIST_W-1:0] sat_dist(input logic [SUM_W-1:0] s);
		return (64'(s) > 64'(DIST_MAX)) ? DIST_MAX : DIST_W'(s);
	endfunction

endpackage

@@ rtl/nvls_if.sv @@
// ----------------------------------------------------------------------------
// nvls_if
// Valid/ready channels of the L1 search: items, results and register writes.
// ----------------------------------------------------------------------------
interface nvls_item_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [3:0]                  row;
	logic [5:0]                  col;
	logic signed [15:0]          value;
	logic                        last;

	modport source (output valid, kind, row, col, value, last, input ready);
	modport sink   (input valid, kind, row, col, value, last, output ready);
endinterface

interface nvls_result_if;
	logic        valid;
	logic        ready;
	logic [3:0]  nearest_row;
	logic        found;
	logic [21:0] min_distance;

	modport source (output valid, nearest_row, found, min_distance, input ready);
	modport sink   (input valid, nearest_row, found, min_distance, output ready);
endinterface

interface nvls_cfg_if;
	logic       valid;
	logic       ready;
	logic [1:0] index;
	logic [6:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

@@ rtl/nvls_ctrl.sv @@
// ----------------------------------------------------------------------------
// nvls_ctrl
// Search sequencer: holds the configuration, walks rows and columns, and
// hands the finished result to the output register.
// ----------------------------------------------------------------------------
module nvls_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	nvls_cfg_if.sink            cfg,
	input  logic                in_fire,
	input  logic                in_kind,
	input  logic                in_last,
	output logic                in_ready,
	output nvls_pkg::nvls_cmd_t cmd,
	input  nvls_pkg::nvls_sts_t sts
);
	import nvls_pkg::*;

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_DRAIN = 2'd2;
	localparam logic [1:0] ST_DONE  = 2'd3;

	logic [1:0]        state_q;
	logic [RCFG_W-1:0] row_count_q;
	logic [LCFG_W-1:0] vec_len_q;
	logic [RCNT_W-1:0] rows_q;
	logic [LCNT_W-1:0] len_q;
	logic [ROW_AW-1:0] r_q;
	logic [COL_AW-1:0] c_q;

	logic [RCNT_W-1:0] rows_sat;
	logic [LCNT_W-1:0] len_sat;
	logic              start;
	logic              col_end;
	logic              row_end;

	assign cfg.ready = 1'b1;
	assign in_ready  = (state_q == ST_IDLE);

	assign rows_sat = (32'(row_count_q) > MAX_ROWS) ? RCNT_W'(MAX_ROWS) : RCNT_W'(row_count_q);
	assign len_sat  = (32'(vec_len_q) > MAX_LEN) ? LCNT_W'(MAX_LEN) : LCNT_W'(vec_len_q);
	assign start    = in_fire && (in_kind == KIND_QUERY) && in_last;

	assign col_end = ((32'(c_q) + 1) == 32'(len_q));
	assign row_end = ((32'(r_q) + 1) == 32'(rows_q));

	always_comb begin
		cmd            = '0;
		cmd.row        = r_q;
		cmd.col        = c_q;
		cmd.first      = (c_q == '0);
		cmd.row_last   = col_end;
		cmd.issue      = (state_q == ST_RUN);
		cmd.init_best  = start;
		cmd.init_found = (rows_sat != '0) && (len_sat == '0);
		cmd.load_out   = (state_q == ST_DONE) && sts.out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_count_q <= '0;
			vec_len_q   <= LCFG_W'(64);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_ROW_COUNT: row_count_q <= RCFG_W'(cfg.data);
				REG_VEC_LEN:   vec_len_q   <= LCFG_W'(cfg.data);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			rows_q  <= '0;
			len_q   <= '0;
			r_q     <= '0;
			c_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						rows_q <= rows_sat;
						len_q  <= len_sat;
						r_q    <= '0;
						c_q    <= '0;
						// nothing to scan: the initial best is already the answer
						state_q <= ((rows_sat == '0) || (len_sat == '0)) ? ST_DONE : ST_RUN;
					end
				end
				ST_RUN: begin
					if (col_end) begin
						c_q <= '0;
						if (row_end) begin
							state_q <= ST_DRAIN;
						end else begin
							r_q <= r_q + 1'b1;
						end
					end else begin
						c_q <= c_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					if (!sts.pipe_busy) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (sts.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/nvls_datapath.sv @@
// ----------------------------------------------------------------------------
// nvls_datapath
// Reference and query memories, absolute-difference accumulator, running
// minimum and the output register.
// ----------------------------------------------------------------------------
module nvls_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_fire,
	input  logic                in_kind,
	input  logic [3:0]          in_row,
	input  logic [5:0]          in_col,
	input  logic signed [15:0]  in_value,
	input  nvls_pkg::nvls_cmd_t cmd,
	output nvls_pkg::nvls_sts_t sts,
	nvls_result_if.source       result
);
	import nvls_pkg::*;

	logic [VAL_W-1:0] ref_mem [0:REF_DEPTH-1];
	logic [VAL_W-1:0] qry_mem [0:QRY_DEPTH-1];

	logic              ref_we;
	logic              qry_we;
	logic [REF_AW-1:0] ref_waddr;
	logic [REF_AW-1:0] ref_raddr;

	// stage 1: memory read data
	logic              v_s1;
	logic              first_s1;
	logic              rlast_s1;
	logic [ROW_AW-1:0] row_s1;
	logic [VAL_W-1:0]  ref_s1;
	logic [VAL_W-1:0]  qry_s1;

	// stage 2: absolute difference
	logic signed [VAL_W:0] diff;
	logic              v_s2;
	logic              first_s2;
	logic              rlast_s2;
	logic [ROW_AW-1:0] row_s2;
	logic [VAL_W-1:0]  abs_s2;

	// stage 3: row sum
	logic              done_s3;
	logic [ROW_AW-1:0] row_s3;
	logic [SUM_W-1:0]  acc_s3;

	logic              found_q;
	logic [ROW_AW-1:0] best_row_q;
	logic [SUM_W-1:0]  best_q;

	logic              out_valid_q;
	logic [ROW_W-1:0]  out_row_q;
	logic              out_found_q;
	logic [DIST_W-1:0] out_dist_q;

	assign ref_we = in_fire && (in_kind == KIND_REF)
		&& (32'(in_row) < MAX_ROWS) && (32'(in_col) < MAX_LEN);
	assign qry_we = in_fire && (in_kind == KIND_QUERY) && (32'(in_col) < MAX_LEN);
	assign ref_waddr = {ROW_AW'(in_row), COL_AW'(in_col)};
	assign ref_raddr = {cmd.row, cmd.col};

	always_ff @(posedge clk) begin
		if (ref_we) begin
			ref_mem[ref_waddr] <= in_value;
		end
		if (cmd.issue) begin
			ref_s1 <= ref_mem[ref_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (qry_we) begin
			qry_mem[COL_AW'(in_col)] <= in_value;
		end
		if (cmd.issue) begin
			qry_s1 <= qry_mem[cmd.col];
		end
	end

	assign diff = $signed({qry_s1[VAL_W-1], qry_s1}) - $signed({ref_s1[VAL_W-1], ref_s1});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			done_s3 <= 1'b0;
		end else begin
			v_s1    <= cmd.issue;
			v_s2    <= v_s1;
			done_s3 <= v_s2 && rlast_s2;
		end
	end

	always_ff @(posedge clk) begin
		first_s1 <= cmd.first;
		rlast_s1 <= cmd.row_last;
		row_s1   <= cmd.row;
		first_s2 <= first_s1;
		rlast_s2 <= rlast_s1;
		row_s2   <= row_s1;
		abs_s2   <= diff[VAL_W] ? VAL_W'(-diff) : VAL_W'(diff);
		if (v_s2) begin
			row_s3 <= row_s2;
			acc_s3 <= first_s2 ? SUM_W'(abs_s2) : acc_s3 + SUM_W'(abs_s2);
		end
	end

	// strict compare keeps the lowest row on a tie
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q    <= 1'b0;
			best_row_q <= '0;
			best_q     <= '0;
		end else if (cmd.init_best) begin
			found_q    <= cmd.init_found;
			best_row_q <= '0;
			best_q     <= '0;
		end else if (done_s3 && (!found_q || (acc_s3 < best_q))) begin
			found_q    <= 1'b1;
			best_row_q <= row_s3;
			best_q     <= acc_s3;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_row_q   <= ROW_W'(best_row_q);
			out_found_q <= found_q;
			out_dist_q  <= sat_dist(best_q);
		end
	end

	assign sts.pipe_busy = v_s1 || v_s2 || done_s3;
	assign sts.out_free  = !out_valid_q || result.ready;

	assign result.valid        = out_valid_q;
	assign result.nearest_row  = out_row_q;
	assign result.found        = out_found_q;
	assign result.min_distance = out_dist_q;

endmodule

@@ rtl/nearest_vector_l1_search.sv @@
// ----------------------------------------------------------------------------
// nearest_vector_l1_search
// Nearest stored reference vector by L1 distance, Q8.8 elements.
// ----------------------------------------------------------------------------
// Usage:
//   item   : kind 0 writes value into reference row/col; kind 1 writes the
//            query element at col. A query element with last set starts a
//            search over row_count rows and vec_len elements.
//   result : one request per search with nearest_row, found, min_distance.
//   cfg    : index 0 row_count, index 1 vec_len; always ready. Write only
//            while no search is pending.
//   Write and query items are taken only while idle. A search scans one
//   element a cycle through the separate reference and query memory read
//   ports, then waits for the pipeline to drain and the output register to
//   be free; items are refused meanwhile. Zero rows or zero length skip
//   the scan and go straight to the result.
//   A finished result waits in the output register while new items are
//   taken; a further search holds its answer until the receiver takes the
//   earlier one.
//   Reset: row_count 0, vec_len 64, no result pending. Memory contents are
//   undefined until written.
// ----------------------------------------------------------------------------
`include "nearest_vector_l1_search_macros.svh"

module nearest_vector_l1_search (
	input  logic           clk,
	input  logic           arst_n,
	nvls_item_if.sink      item,
	nvls_result_if.source  result,
	nvls_cfg_if.sink       cfg
);
	import nvls_pkg::*;

	nvls_cmd_t cmd;
	nvls_sts_t sts;
	logic      in_ready;
	logic      in_fire;

	assign item.ready = in_ready;
	assign in_fire    = item.valid && in_ready;

	nvls_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_fire  (in_fire),
		.in_kind  (item.kind),
		.in_last  (item.last),
		.in_ready (in_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

	nvls_datapath u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.in_kind  (item.kind),
		.in_row   (item.row),
		.in_col   (item.col),
		.in_value (item.value),
		.cmd      (cmd),
		.sts      (sts),
		.result   (result)
	);

	`NVLS_ASSERT(a_no_accept_busy, !(in_ready && sts.pipe_busy), "item accepted during scan")
	`NVLS_ASSERT(a_issue_not_idle, !(cmd.issue && in_ready), "scan issued while idle")
	`NVLS_ASSERT(a_load_when_free, !cmd.load_out || sts.out_free, "result overwritten")
	`NVLS_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, result.valid, "loaded result not shown")

endmodule
